### rtl/pfw_pkg.sv
// shared types and constants of the per-peer fixed-window rate limiter
package pfw_pkg;

    typedef enum logic [1:0] {
        OP_ALLOW  = 2'd0,
        OP_REPORT = 2'd1,
        OP_COUNT  = 2'd2,
        OP_TOTAL  = 2'd3
    } op_t;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

    localparam logic [31:0] MAX_MESSAGES_RESET  = 32'd100;
    localparam logic [31:0] WINDOW_LENGTH_RESET = 32'd60;

    // one table entry as stored in the entry memory
    typedef struct packed {
        logic        valid;
        logic [31:0] peer;
        logic [3:0]  mtype;
        logic [39:0] start;
        logic [31:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // per-entry evaluation result handed from the evaluator to the sequencer
    typedef struct packed {
        logic        vld;
        logic        last;
        logic        match;
        logic        peer_match;
        logic        free;
        logic        dead;
        logic        stale;
        logic [39:0] start;
        logic [31:0] count;
        logic [31:0] live;
    } eval_t;

endpackage

### rtl/per_peer_fixed_window_rate_limiter.sv
// top level of the per-peer fixed-window rate limiter: sequencer and table walk
//
// usage
//   s_* channel: one request per transaction; s_tuser carries the operation
//   (allow, invalid-message report, count for peer and type, peer total).
//   m_* channel: exactly one response per request, in request order.
//   cfg_* channel: register writes (0 max_messages, 1 window_length), always
//   ready; write only while no request is outstanding.
// table walk
//   a request walks the entry memory one entry per cycle through a read port
//   with a registered read and a registered evaluator. an allow that finds no
//   free entry but a dead one walks the table again to prune first. a report
//   runs two allow checks back to back. malformed ids, time zero, a zero window
//   length and, for allow and report, a zero max_messages answer without a walk.
// reset
//   the control registers and settings return to defaults, then a clearing pass
//   writes every entry invalid, one per cycle, with s_tready low.
// stall
//   the response sits in an output register; the next request is taken while
//   it waits, and the block holds its finished result until m_tready frees it.
module per_peer_fixed_window_rate_limiter
    import pfw_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [79:0]          s_tdata,   // peer_id, id_ok, message_type, now, zero pad
    input  logic [1:0]           s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // allowed, count, zero pad
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_CHECK  = 8'b0000_0100,
        ST_SCAN   = 8'b0000_1000,
        ST_DECIDE = 8'b0001_0000,
        ST_PRUNE  = 8'b0010_0000,
        ST_UPDATE = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // request registers
    op_t         op_reg, op_next;
    logic [31:0] peer_reg, peer_next;
    logic        ok_reg, ok_next;
    logic [3:0]  type_reg, type_next;
    logic [39:0] now_reg, now_next;

    // configuration
    logic [31:0] max_reg, max_next;
    logic [31:0] win_reg, win_next;

    // walk control
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             issue_reg, issue_next;
    logic             rd_vld_reg;
    logic             rd_last_reg;
    logic [IDX_W-1:0] rd_idx_d_reg;

    // scan results
    logic             found_reg, found_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic             match_stale_reg, match_stale_next;
    logic [39:0]      match_start_reg, match_start_next;
    logic [31:0]      match_count_reg, match_count_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             dead_found_reg, dead_found_next;
    logic [IDX_W-1:0] dead_idx_reg, dead_idx_next;
    logic [31:0]      total_reg, total_next;

    // update and report bookkeeping
    logic [IDX_W-1:0] target_reg, target_next;
    logic             new_entry_reg, new_entry_next;
    logic             check2_reg, check2_next;
    logic             allowed1_reg, allowed1_next;

    // pending and output result
    logic        res_allowed_reg, res_allowed_next;
    logic [31:0] res_count_reg, res_count_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_allowed_reg, out_allowed_next;
    logic [31:0] out_count_reg, out_count_next;

    // memory ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    eval_t            ev;
    logic [IDX_W-1:0] ev_idx;

    logic        accept;
    logic        bad_req;
    logic        scan_start;
    logic        check_done;
    logic        check_pass;
    logic [32:0] sum_wide;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_count_reg, out_allowed_reg};

    pfw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    pfw_eval #(
        .IDX_W (IDX_W)
    ) u_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_vld        (rd_vld_reg),
        .in_last       (rd_last_reg),
        .in_idx        (rd_idx_d_reg),
        .word          (entry_t'(ram_rdata)),
        .key_peer      (peer_reg),
        .key_type      (type_reg),
        .now           (now_reg),
        .window_length (win_reg),
        .ev            (ev),
        .ev_idx        (ev_idx)
    );

    // read issue: one entry per cycle while a walk is active
    assign ram_re = issue_reg;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        peer_next        = peer_reg;
        ok_next          = ok_reg;
        type_next        = type_reg;
        now_next         = now_reg;
        max_next         = max_reg;
        win_next         = win_reg;
        clr_idx_next     = clr_idx_reg;
        rd_idx_next      = rd_idx_reg;
        issue_next       = issue_reg;
        found_next       = found_reg;
        match_idx_next   = match_idx_reg;
        match_stale_next = match_stale_reg;
        match_start_next = match_start_reg;
        match_count_next = match_count_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        dead_found_next  = dead_found_reg;
        dead_idx_next    = dead_idx_reg;
        total_next       = total_reg;
        target_next      = target_reg;
        new_entry_next   = new_entry_reg;
        check2_next      = check2_reg;
        allowed1_next    = allowed1_reg;
        res_allowed_next = res_allowed_reg;
        res_count_next   = res_count_reg;
        out_valid_next   = out_valid_reg;
        out_allowed_next = out_allowed_reg;
        out_count_next   = out_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = clr_idx_reg;
        ram_wdata        = '0;
        scan_start       = 1'b0;
        check_done       = 1'b0;
        check_pass       = 1'b0;
        bad_req          = !ok_reg || (now_reg == 40'd0) || (win_reg == 32'd0);
        sum_wide         = {1'b0, total_reg} + {1'b0, ev.live};

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_MESSAGES:  max_next = cfg_data;
                CFG_WINDOW_LENGTH: win_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (issue_reg)
        begin
            if (rd_idx_reg == LAST_IDX)
            begin
                issue_next = 1'b0;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op_t'(s_tuser);
                    peer_next   = s_tdata[31:0];
                    ok_next     = s_tdata[32];
                    type_next   = s_tdata[36:33];
                    now_next    = s_tdata[76:37];
                    check2_next = 1'b0;
                    state_next  = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (bad_req || (((op_reg == OP_ALLOW) || (op_reg == OP_REPORT))
                                && (max_reg == 32'd0)))
                begin
                    res_allowed_next = 1'b0;
                    res_count_next   = 32'd0;
                    state_next       = ST_DONE;
                end
                else
                begin
                    scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (ev.vld)
                begin
                    if (ev.match && !found_reg)
                    begin
                        found_next       = 1'b1;
                        match_idx_next   = ev_idx;
                        match_stale_next = ev.stale;
                        match_start_next = ev.start;
                        match_count_next = ev.count;
                    end
                    if (ev.free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = ev_idx;
                    end
                    if (ev.dead && !dead_found_reg)
                    begin
                        dead_found_next = 1'b1;
                        dead_idx_next   = ev_idx;
                    end
                    // saturating peer total
                    if (ev.peer_match)
                    begin
                        total_next = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
                    end
                    if (ev.last)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                unique case (op_reg)
                    OP_COUNT:
                    begin
                        res_allowed_next = 1'b0;
                        res_count_next   = (found_reg && !match_stale_reg) ?
                                           match_count_reg : 32'd0;
                        state_next       = ST_DONE;
                    end
                    OP_TOTAL:
                    begin
                        res_allowed_next = 1'b0;
                        res_count_next   = total_reg;
                        state_next       = ST_DONE;
                    end
                    default:
                    begin
                        priority if (found_reg)
                        begin
                            target_next    = match_idx_reg;
                            new_entry_next = 1'b0;
                            state_next     = ST_UPDATE;
                        end
                        else if (free_found_reg)
                        begin
                            target_next    = free_idx_reg;
                            new_entry_next = 1'b1;
                            state_next     = ST_UPDATE;
                        end
                        else if (dead_found_reg)
                        begin
                            // full table: free every dead entry, reuse the lowest
                            target_next    = dead_idx_reg;
                            new_entry_next = 1'b1;
                            rd_idx_next    = '0;
                            issue_next     = 1'b1;
                            state_next     = ST_PRUNE;
                        end
                        else
                        begin
                            check_done = 1'b1;
                            check_pass = 1'b0;
                        end
                    end
                endcase
            end

            ST_PRUNE:
            begin
                if (ev.vld)
                begin
                    if (ev.dead)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ev_idx;
                        ram_wdata = '0;
                    end
                    if (ev.last)
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end

            ST_UPDATE:
            begin
                check_done = 1'b1;
                ram_waddr  = target_reg;
                ram_wdata.valid = 1'b1;
                ram_wdata.peer  = peer_reg;
                ram_wdata.mtype = type_reg;
                priority if (new_entry_reg || match_stale_reg)
                begin
                    // fresh window, first message counted
                    ram_we          = 1'b1;
                    ram_wdata.start = now_reg;
                    ram_wdata.count = 32'd1;
                    check_pass      = 1'b1;
                end
                else if (match_count_reg >= max_reg)
                begin
                    check_pass = 1'b0;
                end
                else
                begin
                    // same window, one more message
                    ram_we          = 1'b1;
                    ram_wdata.start = match_start_reg;
                    ram_wdata.count = match_count_reg + 32'd1;
                    check_pass      = 1'b1;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_allowed_next = res_allowed_reg;
                    out_count_next   = res_count_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // end of one allow check: a report runs a second one
        if (check_done)
        begin
            if ((op_reg == OP_REPORT) && !check2_reg)
            begin
                allowed1_next = check_pass;
                check2_next   = 1'b1;
                scan_start    = 1'b1;
                state_next    = ST_SCAN;
            end
            else
            begin
                res_allowed_next = (op_reg == OP_REPORT) ? (allowed1_reg && check_pass)
                                                         : check_pass;
                res_count_next   = 32'd0;
                state_next       = ST_DONE;
            end
        end

        if (scan_start)
        begin
            rd_idx_next     = '0;
            issue_next      = 1'b1;
            found_next      = 1'b0;
            free_found_next = 1'b0;
            dead_found_next = 1'b0;
            total_next      = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            max_reg         <= MAX_MESSAGES_RESET;
            win_reg         <= WINDOW_LENGTH_RESET;
            clr_idx_reg     <= '0;
            rd_idx_reg      <= '0;
            issue_reg       <= 1'b0;
            rd_vld_reg      <= 1'b0;
            rd_last_reg     <= 1'b0;
            found_reg       <= 1'b0;
            free_found_reg  <= 1'b0;
            dead_found_reg  <= 1'b0;
            new_entry_reg   <= 1'b0;
            check2_reg      <= 1'b0;
            allowed1_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            match_stale_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            max_reg         <= max_next;
            win_reg         <= win_next;
            clr_idx_reg     <= clr_idx_next;
            rd_idx_reg      <= rd_idx_next;
            issue_reg       <= issue_next;
            rd_vld_reg      <= issue_reg;
            rd_last_reg     <= issue_reg && (rd_idx_reg == LAST_IDX);
            found_reg       <= found_next;
            free_found_reg  <= free_found_next;
            dead_found_reg  <= dead_found_next;
            new_entry_reg   <= new_entry_next;
            check2_reg      <= check2_next;
            allowed1_reg    <= allowed1_next;
            out_valid_reg   <= out_valid_next;
            match_stale_reg <= match_stale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        peer_reg        <= peer_next;
        ok_reg          <= ok_next;
        type_reg        <= type_next;
        now_reg         <= now_next;
        rd_idx_d_reg    <= rd_idx_reg;
        match_idx_reg   <= match_idx_next;
        match_start_reg <= match_start_next;
        match_count_reg <= match_count_next;
        free_idx_reg    <= free_idx_next;
        dead_idx_reg    <= dead_idx_next;
        total_reg       <= total_next;
        target_reg      <= target_next;
        res_allowed_reg <= res_allowed_next;
        res_count_reg   <= res_count_next;
        out_allowed_reg <= out_allowed_next;
        out_count_reg   <= out_count_next;
    end

`ifndef SYNTH
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("entry memory written while idle");

    a_new_entry_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPDATE) && new_entry_reg) |-> (free_found_reg || dead_found_reg))
        else $error("new entry without a free or pruned slot");

    a_allow_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[32:1] == 32'd0))
        else $error("admitted response carries a count");

    a_walk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> ((state_reg == ST_SCAN) || (state_reg == ST_PRUNE)))
        else $error("table walk outside scan or prune");
`endif

endmodule

### rtl/pfw_ram.sv
// generic simple dual-port ram with registered read
module pfw_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pfw_eval.sv
// per-entry evaluator: key match, window staleness and live count, registered
module pfw_eval
    import pfw_pkg::*;
#(
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  logic             in_last,
    input  logic [IDX_W-1:0] in_idx,
    input  entry_t           word,
    input  logic [31:0]      key_peer,
    input  logic [3:0]       key_type,
    input  logic [39:0]      now,
    input  logic [31:0]      window_length,
    output eval_t            ev,
    output logic [IDX_W-1:0] ev_idx
);

    eval_t            ev_reg;
    eval_t            ev_next;
    logic [IDX_W-1:0] ev_idx_reg;
    logic [39:0]      age;
    logic             stale;
    logic             peer_eq;

    always_comb
    begin
        age     = now - word.start;
        stale   = (now < word.start) || (age >= {8'd0, window_length});
        peer_eq = word.valid && (word.peer == key_peer);

        ev_next.vld        = in_vld;
        ev_next.last       = in_last;
        ev_next.peer_match = peer_eq;
        ev_next.match      = peer_eq && (word.mtype == key_type);
        ev_next.free       = !word.valid;
        // expired, time-reversed or never counted
        ev_next.dead       = word.valid && (stale || (word.count == 32'd0));
        ev_next.stale      = stale;
        ev_next.start      = word.start;
        ev_next.count      = word.count;
        ev_next.live       = stale ? 32'd0 : word.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= '0;
        end
        else
        begin
            ev_reg <= ev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_idx_reg <= in_idx;
    end

    assign ev     = ev_reg;
    assign ev_idx = ev_idx_reg;

endmodule
